// ----- hdl/dpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// dpfa_pkg
// Shared types and codes for the dual pool slot allocator: request opcodes,
// result status codes, control state and the pool control/response bundles.
// ----------------------------------------------------------------------------
package dpfa_pkg;

	// request opcodes
	typedef enum logic [1:0] {
		OP_ALLOC_TRACK = 2'd0,
		OP_FREE_TRACK  = 2'd1,
		OP_ALLOC_SUB   = 2'd2,
		OP_FREE_SUB    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_BADFREE = 2'd2
	} status_t;

	// control state of the top level
	typedef enum logic {
		S_IDLE   = 1'b0,
		S_LOOKUP = 1'b1
	} state_t;

	// control from the top level to one pool
	typedef struct packed {
		logic lookup;   // request accepted for this pool, start memory reads
		logic push;     // the request is a free
		logic commit;   // apply the pending request this cycle
	} pool_ctl_t;

	// response from one pool for its pending request
	typedef struct packed {
		logic       ok;
		logic [7:0] granted;
	} pool_rsp_t;

endpackage

// ----- hdl/dpfa_pool.sv -----
// ----------------------------------------------------------------------------
// dpfa_pool
// One slot pool: a free-index queue held in a synchronous memory plus one
// in-use bit per slot. A lookup reads the queue head and the in-use bit of
// the freed index; the commit pops or pushes and updates the bits.
// ----------------------------------------------------------------------------
module dpfa_pool #(
	parameter int SLOTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dpfa_pkg::pool_ctl_t ctl,
	input  logic [7:0]          slot_index,
	output dpfa_pkg::pool_rsp_t rsp
);
	import dpfa_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [8:0] SLOTS_W = 9'(SLOTS);
	localparam logic [IW-1:0] LAST_POS = IW'(SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

	// queue memory and its registered read
	logic [IW-1:0] queue_mem [SLOTS];
	logic [IW-1:0] head_rd_s1;

	// queue pointers, occupancy and the count of queue positions ever written
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] fill_q;
	logic [SLOTS-1:0] in_use_q;

	// pending request
	logic          active_s1;
	logic          push_s1;
	logic [7:0]    idx_s1;
	logic          used_s1;

	logic          in_range;
	logic [IW-1:0] idx_lo;
	logic [IW-1:0] head_val;
	logic          pop_ok;
	logic          push_ok;
	logic          wr_en;

	assign idx_lo   = idx_s1[IW-1:0];
	assign in_range = {1'b0, idx_s1} < SLOTS_W;

	// a position never written still holds its reset value, its own index
	assign head_val = (CW'(head_q) < fill_q) ? head_rd_s1 : head_q;

	assign pop_ok  = active_s1 && !push_s1 && (count_q != '0);
	assign push_ok = active_s1 && push_s1 && in_range && used_s1 && (count_q < FULL_CNT);
	assign wr_en   = ctl.commit && push_ok;

	assign rsp.ok      = pop_ok || push_ok;
	assign rsp.granted = pop_ok ? 8'(head_val) : 8'd0;

	// queue memory: push writes at tail, lookup reads at head
	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_mem[tail_q] <= idx_lo;
		end
		if (ctl.lookup) begin
			head_rd_s1 <= queue_mem[head_q];
		end
	end

	// capture of the pending request
	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			push_s1 <= ctl.push;
			idx_s1  <= slot_index;
			used_s1 <= in_use_q[slot_index[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
		end else if (ctl.lookup) begin
			active_s1 <= 1'b1;
		end else if (ctl.commit) begin
			active_s1 <= 1'b0;
		end
	end

	// pointer, count and in-use update at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= FULL_CNT;
			fill_q   <= '0;
			in_use_q <= '0;
		end else if (ctl.commit) begin
			if (pop_ok) begin
				in_use_q[head_val] <= 1'b1;
				head_q  <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (push_ok) begin
				in_use_q[idx_lo] <= 1'b0;
				tail_q  <= (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
				if (fill_q != FULL_CNT) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// queue bookkeeping stays consistent
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("pool count above pool size");

	a_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((CW + 1)'(head_q) + (CW + 1)'(count_q) == (CW + 1)'(tail_q)) ||
		((CW + 1)'(head_q) + (CW + 1)'(count_q) == (CW + 1)'(tail_q) + (CW + 1)'(SLOTS)))
		else $error("head, count and tail disagree");

	a_pop_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit && pop_ok |=> in_use_q[$past(head_val)])
		else $error("popped slot not marked in use");

endmodule

// ----- hdl/dual_pool_fifo_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// dual_pool_fifo_slot_allocator
// Two slot pools, track and sub-track, each handing out free indices oldest
// first and taking freed indices back at the tail of its queue.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries operation and slot_index:
//   allocate or free a track, allocate or free a sub-track. Response channel
//   (rsp_valid/rsp_ready) returns status, granted_index and serial_number,
//   exactly one response per request, in order.
//   Timing: a request is taken at one edge and its pool memory is read on
//   that edge; the result is committed and registered once the response
//   register is free, and the next request is accepted only after that
//   commit. The pace is set by the registered read of the free-queue memory
//   followed by the write-back of the same queue and in-use bits.
//   Reset: both queues hold every index in ascending order, no slot is in
//   use and the serial counter is 1; no clearing pass, requests are taken
//   right after reset.
//   Stall: while a response waits, the next request is still accepted and
//   looked up; it commits once the response register is taken.
// ----------------------------------------------------------------------------
module dual_pool_fifo_slot_allocator #(
	parameter int TRACK_SLOTS    = 64,
	parameter int SUBTRACK_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  slot_index,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [7:0]  granted_index,
	output logic [31:0] serial_number
);
	import dpfa_pkg::*;

	state_t    state_q;
	state_t    state_nxt;
	op_t       op_s1;
	logic      accept;
	logic      commit;
	logic      rsp_free;
	pool_ctl_t track_ctl;
	pool_ctl_t sub_ctl;
	pool_rsp_t track_rsp;
	pool_rsp_t sub_rsp;
	pool_rsp_t sel_rsp;
	status_t   status_nxt;
	logic [31:0] serial_nxt;

	logic        rsp_valid_q;
	status_t     status_q;
	logic [7:0]  granted_q;
	logic [31:0] serial_out_q;
	logic [31:0] next_serial_q;

	assign accept   = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_nxt = S_LOOKUP;
			S_LOOKUP: if (rsp_free) state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			S_IDLE:   req_ready = 1'b1;
			S_LOOKUP: commit    = rsp_free;
			default:  req_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_t'(operation);
		end
	end

	// pool control
	always_comb begin
		track_ctl.lookup = accept && !operation[1];
		track_ctl.push   = operation[0];
		track_ctl.commit = commit && !op_s1[1];
		sub_ctl.lookup   = accept && operation[1];
		sub_ctl.push     = operation[0];
		sub_ctl.commit   = commit && op_s1[1];
	end

	dpfa_pool #(.SLOTS(TRACK_SLOTS)) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (track_ctl),
		.slot_index (slot_index),
		.rsp        (track_rsp)
	);

	dpfa_pool #(.SLOTS(SUBTRACK_SLOTS)) u_sub (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (sub_ctl),
		.slot_index (slot_index),
		.rsp        (sub_rsp)
	);

	// result of the pending request
	always_comb begin
		sel_rsp    = op_s1[1] ? sub_rsp : track_rsp;
		serial_nxt = 32'd0;
		status_nxt = STAT_OK;
		unique case (op_s1)
			OP_ALLOC_TRACK: status_nxt = sel_rsp.ok ? STAT_OK : STAT_EMPTY;
			OP_ALLOC_SUB: begin
				status_nxt = sel_rsp.ok ? STAT_OK : STAT_EMPTY;
				serial_nxt = sel_rsp.ok ? next_serial_q : 32'd0;
			end
			OP_FREE_TRACK,
			OP_FREE_SUB:    status_nxt = sel_rsp.ok ? STAT_OK : STAT_BADFREE;
			default:        status_nxt = STAT_OK;
		endcase
	end

	// serial counter, wraps modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_serial_q <= 32'd1;
		end else if (commit && op_s1 == OP_ALLOC_SUB && sel_rsp.ok) begin
			next_serial_q <= next_serial_q + 32'd1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_nxt;
			granted_q    <= sel_rsp.granted;
			serial_out_q <= serial_nxt;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign serial_number = serial_out_q;

	// one request in flight, one response per commit
	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q)
		else $error("commit without response");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOKUP |-> !accept)
		else $error("request accepted while one is pending");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != STAT_OK |-> granted_q == 8'd0 && serial_out_q == 32'd0)
		else $error("failed request carries a nonzero index or serial");

endmodule
